// ===== sv/lsps_pkg.sv =====
`timescale 1ns / 1ps
package lsps_pkg;

  localparam int SENSE_W       = 12;
  localparam int SAMPLE_BITS   = 12;
  localparam int INTEGRAL_BITS = 24;
  localparam int NUM_SENSORS   = 8;
  localparam int ERR_W         = 5;
  localparam int DERR_W        = ERR_W + 1;
  localparam int GAIN_W        = 20;
  localparam int SPEED_W       = 16;
  localparam int CFG_W         = 20;
  localparam int IDX_W         = 3;

  // product and accumulator widths, gains carried as signed with a zero msb
  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W = GAIN_W + 1 + DERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + INTEGRAL_BITS;
  localparam int ACC_W    = PROD_I_W + 2;
  localparam int PID_W    = ACC_W - 9;
  localparam int SUM_W    = PID_W + 2;

  localparam logic [SENSE_W-1:0] THRESHOLD_RST = SENSE_W'(300);
  localparam logic [GAIN_W-1:0]  GAIN_P_RST    = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST    = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST    = GAIN_W'(7);
  localparam logic [SPEED_W-1:0] SPEED_LIM_RST = SPEED_W'(1792);
  localparam logic [SPEED_W-1:0] SPEED_BASE_RST = SPEED_W'(1280);

  // right outer first, left outer last
  localparam logic signed [ERR_W-1:0] SENSOR_WEIGHT [NUM_SENSORS] = '{
    -5'sd8, -5'sd4, -5'sd2, -5'sd1, 5'sd1, 5'sd2, 5'sd4, 5'sd8
  };

  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_GAIN_I      = 3'd3,
    REG_SPEED_LIMIT = 3'd4,
    REG_SPEED_BASE  = 3'd5
  } reg_index_t;

  typedef logic [NUM_SENSORS-1:0][SENSE_W-1:0] sense_vec_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]         err;
    logic signed [DERR_W-1:0]        derr;
    logic signed [INTEGRAL_BITS-1:0] esum;
  } track_t;

endpackage

// ===== sv/lsps_track.sv =====
`timescale 1ns / 1ps
module lsps_track (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  lsps_pkg::sense_vec_t              sense,
  input  logic [lsps_pkg::SENSE_W-1:0]      threshold,
  output lsps_pkg::track_t                  track
);
  import lsps_pkg::*;

  localparam logic signed [INTEGRAL_BITS:0] IMAX =
    (INTEGRAL_BITS+1)'((64'sd1 <<< (INTEGRAL_BITS-1)) - 64'sd1);
  localparam logic signed [INTEGRAL_BITS:0] IMIN = -IMAX - (INTEGRAL_BITS+1)'(1);

  logic signed [ERR_W-1:0]         last_error;
  logic signed [INTEGRAL_BITS-1:0] error_sum;
  logic signed [ERR_W-1:0]         err;
  logic signed [INTEGRAL_BITS:0]   sum_wide;
  logic signed [INTEGRAL_BITS-1:0] error_sum_next;

  always_comb begin
    err = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (sense[i][SAMPLE_BITS-1:0] > threshold[SAMPLE_BITS-1:0]) begin
        err = err + SENSOR_WEIGHT[i];
      end
    end
  end

  // integrator saturates at the signed range of error_sum
  always_comb begin
    sum_wide = (INTEGRAL_BITS+1)'(error_sum) + (INTEGRAL_BITS+1)'(err);
    if (sum_wide > IMAX) begin
      error_sum_next = IMAX[INTEGRAL_BITS-1:0];
    end else if (sum_wide < IMIN) begin
      error_sum_next = IMIN[INTEGRAL_BITS-1:0];
    end else begin
      error_sum_next = sum_wide[INTEGRAL_BITS-1:0];
    end
  end

  always_comb begin
    track.err  = err;
    track.derr = DERR_W'(err) - DERR_W'(last_error);
    track.esum = error_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
    end else if (advance) begin
      last_error <= err;
      error_sum  <= error_sum_next;
    end
  end

endmodule

// ===== sv/line_sensor_pid_steering.sv =====
`timescale 1ns / 1ps
// pipeline: a request is accepted into the input reg, then passes the error/integrator,
// gain multiplier, pid sum and speed clamp registers before out_valid
// throughput: one request per cycle while out_ready does not stall the pipeline
// reset: rst synchronous, clears pipeline valids, last error and error sum, and loads
// register defaults
module line_sensor_pid_steering (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [lsps_pkg::IDX_W-1:0]         wr_index,
  input  logic [lsps_pkg::CFG_W-1:0]         wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lsps_pkg::SENSE_W-1:0]       right_outer,
  input  logic [lsps_pkg::SENSE_W-1:0]       right_third,
  input  logic [lsps_pkg::SENSE_W-1:0]       right_second,
  input  logic [lsps_pkg::SENSE_W-1:0]       right_inner,
  input  logic [lsps_pkg::SENSE_W-1:0]       left_inner,
  input  logic [lsps_pkg::SENSE_W-1:0]       left_second,
  input  logic [lsps_pkg::SENSE_W-1:0]       left_third,
  input  logic [lsps_pkg::SENSE_W-1:0]       left_outer,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lsps_pkg::SPEED_W-1:0]       left_speed,
  output logic [lsps_pkg::SPEED_W-1:0]       right_speed,
  output logic signed [lsps_pkg::ERR_W-1:0]  position_error
);
  import lsps_pkg::*;

  // configuration registers
  logic [SENSE_W-1:0] sense_threshold;
  logic [GAIN_W-1:0]  gain_prop;
  logic [GAIN_W-1:0]  gain_deriv;
  logic [GAIN_W-1:0]  gain_integ;
  logic [SPEED_W-1:0] speed_limit;
  logic [SPEED_W-1:0] speed_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      sense_threshold <= THRESHOLD_RST;
      gain_prop       <= GAIN_P_RST;
      gain_deriv      <= GAIN_D_RST;
      gain_integ      <= GAIN_I_RST;
      speed_limit     <= SPEED_LIM_RST;
      speed_base      <= SPEED_BASE_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_THRESHOLD:   sense_threshold <= wr_data[SENSE_W-1:0];
        REG_GAIN_P:      gain_prop       <= wr_data[GAIN_W-1:0];
        REG_GAIN_D:      gain_deriv      <= wr_data[GAIN_W-1:0];
        REG_GAIN_I:      gain_integ      <= wr_data[GAIN_W-1:0];
        REG_SPEED_LIMIT: speed_limit     <= wr_data[SPEED_W-1:0];
        REG_SPEED_BASE:  speed_base      <= wr_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic                        s0_valid;
  sense_vec_t                  s0_sense;
  logic                        s1_valid;
  track_t                      s1_track;
  logic                        s2_valid;
  logic signed [ERR_W-1:0]     s2_err;
  logic signed [PROD_P_W-1:0]  s2_prod_p;
  logic signed [PROD_D_W-1:0]  s2_prod_d;
  logic signed [PROD_I_W-1:0]  s2_prod_i;
  logic                        s3_valid;
  logic signed [ERR_W-1:0]     s3_err;
  logic signed [PID_W-1:0]     s3_pid;

  logic   out_free, s3_free, s2_free, s1_free, s0_free;
  track_t track;

  // stall chain, each stage also fills when it is empty, even while its successor stalls
  assign out_free = !out_valid || out_ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s0_free  = !s0_valid || s1_free;
  assign in_ready = s0_free;

  lsps_track u_track (
    .clk       (clk),
    .rst       (rst),
    .advance   (s0_valid && s1_free),
    .sense     (s0_sense),
    .threshold (sense_threshold),
    .track     (track)
  );

  // pid arithmetic
  logic signed [ACC_W-1:0] acc;
  logic signed [SUM_W-1:0] left_sum, right_sum, limit_s;
  logic [SPEED_W-1:0]      left_clamp, right_clamp;

  assign acc = ACC_W'(s2_prod_p) + ACC_W'(s2_prod_d) + ACC_W'(s2_prod_i);

  always_comb begin
    limit_s   = SUM_W'($signed({1'b0, speed_limit}));
    left_sum  = SUM_W'($signed({1'b0, speed_base})) + SUM_W'(s3_pid);
    right_sum = SUM_W'($signed({1'b0, speed_base})) - SUM_W'(s3_pid);
    if (left_sum < 0) begin
      left_clamp = '0;
    end else if (left_sum > limit_s) begin
      left_clamp = speed_limit;
    end else begin
      left_clamp = left_sum[SPEED_W-1:0];
    end
    if (right_sum < 0) begin
      right_clamp = '0;
    end else if (right_sum > limit_s) begin
      right_clamp = speed_limit;
    end else begin
      right_clamp = right_sum[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s0_free) s0_valid <= in_valid;
      if (s1_free) s1_valid <= s0_valid;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
      if (out_free) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_free && in_valid) begin
      s0_sense <= {left_outer, left_third, left_second, left_inner,
                   right_inner, right_second, right_third, right_outer};
    end
    if (s1_free && s0_valid) begin
      s1_track <= track;
    end
    if (s2_free && s1_valid) begin
      s2_err    <= s1_track.err;
      s2_prod_p <= $signed({1'b0, gain_prop}) * s1_track.err;
      s2_prod_d <= $signed({1'b0, gain_deriv}) * s1_track.derr;
      s2_prod_i <= $signed({1'b0, gain_integ}) * s1_track.esum;
    end
    if (s3_free && s2_valid) begin
      s3_err <= s2_err;
      // halving plus the move from q.16 to q8.8, floor rounding
      s3_pid <= PID_W'(acc >>> 9);
    end
    if (out_free && s3_valid) begin
      left_speed     <= left_clamp;
      right_speed    <= right_clamp;
      position_error <= s3_err;
    end
  end

  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position_error != ERR_W'(-16))
    else $error("position error out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s0_valid |-> in_ready)
    else $error("input stalled with empty input stage");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s0_valid)
    else $error("accepted request lost at input stage");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !s0_valid)
    else $error("pipeline not cleared by reset");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import lsps_pkg::*;

  localparam int     DIR_N          = 22;
  localparam int     RAND_PER_PHASE = 130;
  localparam int     DRAIN_CYCLES   = 12;
  localparam int     REPORT_MAX     = 50;
  localparam int     CYCLE_LIMIT    = 2_000_000;
  localparam longint SUM_MAX        = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
  localparam longint SUM_MIN        = -SUM_MAX - 1;

  // indexes past the register file, writes there must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic [0:NUM_SENSORS-1][SENSE_W-1:0] scan_t;

  typedef struct packed {
    logic [SPEED_W-1:0]      left;
    logic [SPEED_W-1:0]      right;
    logic signed [ERR_W-1:0] perr;
  } steer_t;

  typedef struct packed {
    scan_t                   sensors;
    logic                    typed;
    logic [SPEED_W-1:0]      want_left;
    logic [SPEED_W-1:0]      want_right;
    logic signed [ERR_W-1:0] want_err;
  } dir_row_t;

  // sensors listed right outer .. left outer; typed rows carry the speeds after reset
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
      1'b1, 16'd1280, 16'd1280, 5'sd0},
    '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
      1'b1, 16'd1280, 16'd1280, 5'sd0},
    '{'{12'd300, 12'd300, 12'd300, 12'd300, 12'd300, 12'd300, 12'd300, 12'd300},
      1'b1, 16'd1280, 16'd1280, 5'sd0},
    '{'{12'd301, 12'd301, 12'd301, 12'd301, 12'd301, 12'd301, 12'd301, 12'd301},
      1'b1, 16'd1280, 16'd1280, 5'sd0},
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095},
      1'b1, 16'd1792, 16'd0, 5'sd8},
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
      1'b1, 16'd1792, 16'd0, 5'sd15},
    '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0},
      1'b1, 16'd0, 16'd1792, -5'sd15},
    '{'{12'd301, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd0, 12'd301, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd301, 12'd0, 12'd0, 12'd0}, 1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0}, 1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd301, 12'd0}, 1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd301}, 1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0},
      1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095},
      1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA},
      1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'h555, 12'h555, 12'h555, 12'h555, 12'h555, 12'h555, 12'h555, 12'h555},
      1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd299, 12'd299, 12'd299, 12'd299, 12'd299, 12'd299, 12'd299, 12'd299},
      1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd0, 12'd0, 12'd2000, 12'd2000, 12'd0, 12'd0, 12'd0},
      1'b0, 16'd0, 16'd0, 5'sd0},
    '{'{12'd0, 12'd0, 12'd3000, 12'd3000, 12'd3000, 12'd0, 12'd0, 12'd0},
      1'b0, 16'd0, 16'd0, 5'sd0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic [IDX_W-1:0]   wr_index = '0;
  logic [CFG_W-1:0]   wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [SENSE_W-1:0] right_outer = '0;
  logic [SENSE_W-1:0] right_third = '0;
  logic [SENSE_W-1:0] right_second = '0;
  logic [SENSE_W-1:0] right_inner = '0;
  logic [SENSE_W-1:0] left_inner = '0;
  logic [SENSE_W-1:0] left_second = '0;
  logic [SENSE_W-1:0] left_third = '0;
  logic [SENSE_W-1:0] left_outer = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SPEED_W-1:0] left_speed;
  logic [SPEED_W-1:0] right_speed;
  logic signed [ERR_W-1:0] position_error;

  line_sensor_pid_steering u_dut (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .right_outer    (right_outer),
    .right_third    (right_third),
    .right_second   (right_second),
    .right_inner    (right_inner),
    .left_inner     (left_inner),
    .left_second    (left_second),
    .left_third     (left_third),
    .left_outer     (left_outer),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_speed     (left_speed),
    .right_speed    (right_speed),
    .position_error (position_error)
  );

  // steering model: registers and controller state
  longint cfg_thr, cfg_gain_p, cfg_gain_d, cfg_gain_i, cfg_limit, cfg_base;
  longint model_last_err, model_err_sum;

  steer_t steer_q[$];
  int     fail_count = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int unsigned cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_pct == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= $urandom_range(99) >= stall_pct;
    end
  end

  function automatic longint clamp_speed(longint v);
    if (v > cfg_limit) v = cfg_limit;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic steer_t steer_predict(scan_t s);
    longint e, de, acc, pid;
    steer_t r;
    e = 0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (longint'(s[i]) > cfg_thr) e += longint'(SENSOR_WEIGHT[i]);
    end
    de = e - model_last_err;
    model_err_sum += e;
    if (model_err_sum > SUM_MAX) model_err_sum = SUM_MAX;
    if (model_err_sum < SUM_MIN) model_err_sum = SUM_MIN;
    acc = cfg_gain_p * e + cfg_gain_d * de + cfg_gain_i * model_err_sum;
    // halve and drop to Q8.8 in one floor shift
    pid = acc >>> 9;
    model_last_err = e;
    r.left  = SPEED_W'(clamp_speed(cfg_base + pid));
    r.right = SPEED_W'(clamp_speed(cfg_base - pid));
    r.perr  = ERR_W'(e);
    return r;
  endfunction

  function automatic void note_mismatch(string what, longint want_v, longint got_v);
    fail_count++;
    if (fail_count <= REPORT_MAX) $error("%s: expected %0d, got %0d", what, want_v, got_v);
  endfunction

  always @(posedge clk) begin
    steer_t want;
    if (!rst && out_valid && out_ready) begin
      if (steer_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $error("result with no request outstanding: left_speed %0d right_speed %0d",
                 left_speed, right_speed);
      end else begin
        want = steer_q.pop_front();
        if (left_speed !== want.left) note_mismatch("left_speed", want.left, left_speed);
        if (right_speed !== want.right) note_mismatch("right_speed", want.right, right_speed);
        if (position_error !== want.perr)
          note_mismatch("position_error", $signed(want.perr), $signed(position_error));
      end
    end
  end

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD:   cfg_thr    = longint'(val[SENSE_W-1:0]);
      REG_GAIN_P:      cfg_gain_p = longint'(val[GAIN_W-1:0]);
      REG_GAIN_D:      cfg_gain_d = longint'(val[GAIN_W-1:0]);
      REG_GAIN_I:      cfg_gain_i = longint'(val[GAIN_W-1:0]);
      REG_SPEED_LIMIT: cfg_limit  = longint'(val[SPEED_W-1:0]);
      REG_SPEED_BASE:  cfg_base   = longint'(val[SPEED_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [CFG_W-1:0] thr, gp, gd, gi, lim, base);
    reg_write(REG_THRESHOLD, thr);
    reg_write(REG_GAIN_P, gp);
    reg_write(REG_GAIN_D, gd);
    reg_write(REG_GAIN_I, gi);
    reg_write(REG_SPEED_LIMIT, lim);
    reg_write(REG_SPEED_BASE, base);
    reg_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
    wr_en <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] rand_gain();
    return CFG_W'($urandom) >> $urandom_range(CFG_W - 1);
  endfunction

  task automatic program_random();
    program_regs(CFG_W'($urandom), rand_gain(), rand_gain(), rand_gain(),
                 CFG_W'($urandom), CFG_W'($urandom));
  endtask

  task automatic send_scan(scan_t s, logic typed, steer_t typed_res);
    steer_t pred;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    right_outer  <= s[0];
    right_third  <= s[1];
    right_second <= s[2];
    right_inner  <= s[3];
    left_inner   <= s[4];
    left_second  <= s[5];
    left_third   <= s[6];
    left_outer   <= s[7];
    do @(posedge clk); while (!in_ready);
    pred = steer_predict(s);
    steer_q.push_back(typed ? typed_res : pred);
  endtask

  // readings cluster near the threshold and the rails so every pattern shows up
  function automatic scan_t rand_scan();
    scan_t s;
    int k, v;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      k = $urandom_range(9);
      if (k < 4) v = $urandom_range(4095);
      else if (k < 7) v = int'(cfg_thr) + int'($urandom_range(2)) - 1;
      else v = $urandom_range(1) ? 4095 : 0;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      s[i] = SENSE_W'(v);
    end
    return s;
  endfunction

  // line fully under one side: left side gives +15, right side -15
  function automatic scan_t side_scan(bit left_side);
    scan_t s;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if ((i >= NUM_SENSORS / 2) == left_side)
        s[i] = SENSE_W'($urandom_range(4095, int'(cfg_thr) + 1));
      else
        s[i] = SENSE_W'($urandom_range(int'(cfg_thr)));
    end
    return s;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_scan(rand_scan(), 1'b0, '0);
  endtask

  task automatic run_side(bit left_side, int n);
    for (int i = 0; i < n; i++) send_scan(side_scan(left_side), 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    steer_t row_res;
    cfg_thr        = longint'(THRESHOLD_RST);
    cfg_gain_p     = longint'(GAIN_P_RST);
    cfg_gain_d     = longint'(GAIN_D_RST);
    cfg_gain_i     = longint'(GAIN_I_RST);
    cfg_limit      = longint'(SPEED_LIM_RST);
    cfg_base       = longint'(SPEED_BASE_RST);
    model_last_err = 0;
    model_err_sum  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults straight out of reset
    for (int i = 0; i < DIR_N; i++) begin
      row_res.left  = DIRECTED[i].want_left;
      row_res.right = DIRECTED[i].want_right;
      row_res.perr  = DIRECTED[i].want_err;
      send_scan(DIRECTED[i].sensors, DIRECTED[i].typed, row_res);
    end
    run_random(RAND_PER_PHASE);
    drain();

    idle_pct = 54;
    program_random();
    run_random(RAND_PER_PHASE);
    drain();

    // every sample above zero is line, gains and limit at full scale
    idle_pct  = 0;
    stall_pct = 54;
    program_regs(CFG_W'(0), 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, CFG_W'(0));
    run_random(RAND_PER_PHASE);
    drain();

    // nothing can be detected and the limit pins both wheels at zero
    idle_pct  = 8;
    stall_pct = 8;
    program_regs(CFG_W'(4095), CFG_W'(0), CFG_W'(0), CFG_W'(0), CFG_W'(0), CFG_W'(0));
    run_random(60);
    drain();

    program_random();
    run_random(RAND_PER_PHASE);
    drain();

    idle_pct  = 0;
    stall_pct = 0;
    program_random();
    run_random(120);
    drain();

    // line held under the left side with the default registers
    program_regs(CFG_W'(THRESHOLD_RST), CFG_W'(GAIN_P_RST), CFG_W'(GAIN_D_RST),
                 CFG_W'(GAIN_I_RST), CFG_W'(SPEED_LIM_RST), CFG_W'(SPEED_BASE_RST));
    run_side(1'b1, 20);
    drain();

    // integral term alone, wide limit, so the running sum shows in the speeds
    program_regs(CFG_W'(THRESHOLD_RST), CFG_W'(0), CFG_W'(0), CFG_W'(1), 20'hFFFF, 20'h8000);
    run_side(1'b1, 20);
    run_side(1'b0, 40);
    run_side(1'b1, 20);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
